[sv/pdsu_pkg.sv]
// pdsu_pkg: widths, limits and register map of the pll divider search unit
// no dependencies; imported by the interfaces and every module of the block
package pdsu_pkg;

  localparam int PRE_W    = 5;
  localparam int POST_W   = 4;
  localparam int MULT_W   = 9;
  localparam int FRAC_W   = 9;
  localparam int N_W      = MULT_W + FRAC_W;
  localparam int TARGET_W = 31;
  localparam int REF_W    = 32;
  localparam int TD_W     = TARGET_W + POST_W + FRAC_W;
  localparam int PROD_W   = REF_W + N_W;
  localparam int CMP_W    = TD_W + POST_W + 1;
  localparam int ERR_W    = 50;
  localparam int FREQ_W   = 50;
  localparam int DEN_W    = 14;

  localparam int DIV_CNT_W = $clog2(TD_W + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TD_W - 1);

  localparam logic [PRE_W-1:0]  PRE_FIRST = PRE_W'(1);
  localparam logic [PRE_W-1:0]  PRE_LAST  = '1;
  localparam logic [POST_W-1:0] POST_LAST = '1;
  localparam logic [N_W-1:0]    N_MAX     = '1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_REF_CLOCK = CFG_ADDR_W'(0);
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(24000000);

endpackage

[sv/pdsu_in_if.sv]
// pdsu_in_if: request channel carrying the target frequency
// depends on pdsu_pkg
interface pdsu_in_if import pdsu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target_hz;

  modport source(output valid, target_hz, input ready);
  modport sink(input valid, target_hz, output ready);
endinterface

[sv/pdsu_out_if.sv]
// pdsu_out_if: result channel carrying the best divider settings
// depends on pdsu_pkg
interface pdsu_out_if import pdsu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [PRE_W-1:0]  pre_div;
  logic [MULT_W-1:0] feedback_int;
  logic [POST_W-1:0] post_code;
  logic [FRAC_W-1:0] feedback_frac;
  logic [ERR_W-1:0]  error_num;
  logic [FREQ_W-1:0] freq_num;
  logic [DEN_W-1:0]  denom;
  logic              exact_hit;

  modport source(output valid, pre_div, feedback_int, post_code, feedback_frac,
                 error_num, freq_num, denom, exact_hit, input ready);
  modport sink(input valid, pre_div, feedback_int, post_code, feedback_frac,
               error_num, freq_num, denom, exact_hit, output ready);
endinterface

[sv/pll_divider_search_unit.sv]
// pll_divider_search_unit: fractional pll divider search, sequencer and datapath
// depends on pdsu_pkg, pdsu_in_if, pdsu_out_if, pdsu_div and pdsu_cfg
//
// Each request transaction carries a target frequency and starts a full search over
// pre-divider p = 1..31 and post code s = 0..15. For each p the shared divider forms
// floor(ref/p); for each (p, s) it divides target*512*(s+1) by that quotient to get
// the nearest feedback word (integer and fraction), then rounds, saturates and compares
// the error exactly against the best so far. Every division runs through the 44-step
// shared divider, and a search ends early at the first exact match. The request channel
// is not ready during a search.
// The result register lets the next request start while a result waits to be taken.
module pll_divider_search_unit import pdsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pdsu_in_if.sink               in_chan,
  pdsu_out_if.source            out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_Q_GO, S_Q_WAIT, S_N_GO, S_N_WAIT,
    S_EVAL, S_MUL, S_ERR, S_XMUL, S_CMP, S_DONE
  } state_t;

  state_t state_r;

  logic [REF_W-1:0]    ref_clock;
  logic                div_start;
  logic [TD_W-1:0]     div_dividend;
  logic [REF_W-1:0]    div_divisor;
  logic                div_done;
  logic [TD_W-1:0]     div_quo;
  logic [REF_W-1:0]    div_rem;

  logic [TARGET_W-1:0] target_r;
  logic [PRE_W-1:0]    p_r;
  logic [POST_W-1:0]   s_r;
  logic [REF_W-1:0]    q_r;
  logic [N_W-1:0]      n_r;
  logic [TD_W-1:0]     err_r;
  logic                sat_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CMP_W-1:0]    lhs_r;
  logic [CMP_W-1:0]    rhs_r;
  logic                have_r;

  logic [PRE_W-1:0]    bp_r;
  logic [POST_W-1:0]   bs_r;
  logic [N_W-1:0]      bn_r;
  logic [TD_W-1:0]     berr_r;
  logic [PROD_W-1:0]   bfreq_r;

  logic                out_valid_r;
  logic [PRE_W-1:0]    o_pre_r;
  logic [N_W-1:0]      o_n_r;
  logic [POST_W-1:0]   o_post_r;
  logic [TD_W-1:0]     o_err_r;
  logic [PROD_W-1:0]   o_freq_r;

  logic [POST_W:0]            s_plus1;
  logic [POST_W:0]            bs_plus1;
  logic [POST_W:0]            o_post_plus1;
  logic [TARGET_W+POST_W:0]   tprod;
  logic [TD_W-1:0]            td;
  logic [REF_W-1:0]           e1;
  logic                       n_sat;
  logic [PROD_W-1:0]          err_sub;

  pdsu_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .ref_clock_hz (ref_clock)
  );

  pdsu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    s_plus1      = {1'b0, s_r} + 1'b1;
    bs_plus1     = {1'b0, bs_r} + 1'b1;
    o_post_plus1 = {1'b0, o_post_r} + 1'b1;
    tprod        = target_r * s_plus1;
    td           = {tprod[TD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    div_start    = (state_r == S_Q_GO) || (state_r == S_N_GO && q_r != '0);
    div_dividend = (state_r == S_Q_GO) ? {{(TD_W-REF_W){1'b0}}, ref_clock} : td;
    div_divisor  = (state_r == S_Q_GO) ? {{(REF_W-PRE_W){1'b0}}, p_r} : q_r;
    e1           = q_r - div_rem;
    n_sat        = div_quo >= {{(TD_W-N_W){1'b0}}, N_MAX};
    err_sub      = {{(PROD_W-TD_W){1'b0}}, td} - prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            target_r <= in_chan.target_hz;
            p_r      <= PRE_FIRST;
            s_r      <= '0;
            have_r   <= 1'b0;
            state_r  <= S_Q_GO;
          end
        end
        S_Q_GO: begin
          state_r <= S_Q_WAIT;
        end
        S_Q_WAIT: begin
          if (div_done) begin
            q_r     <= div_quo[REF_W-1:0];
            state_r <= S_N_GO;
          end
        end
        S_N_GO: begin
          state_r <= (q_r == '0) ? S_EVAL : S_N_WAIT;
        end
        S_N_WAIT: begin
          if (div_done) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          sat_r <= 1'b0;
          if (q_r == '0) begin
            n_r   <= '0;
            err_r <= td;
          end else if (n_sat) begin
            n_r   <= N_MAX;
            sat_r <= 1'b1;
          end else if (div_rem <= e1) begin
            n_r   <= div_quo[N_W-1:0];
            err_r <= {{(TD_W-REF_W){1'b0}}, div_rem};
          end else begin
            n_r   <= div_quo[N_W-1:0] + 1'b1;
            err_r <= {{(TD_W-REF_W){1'b0}}, e1};
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(q_r) * PROD_W'(n_r);
          state_r <= S_ERR;
        end
        S_ERR: begin
          if (sat_r) begin
            err_r <= err_sub[TD_W-1:0];
          end
          state_r <= S_XMUL;
        end
        S_XMUL: begin
          // exact ratio compare; the common factor 512 cancels
          lhs_r   <= CMP_W'(err_r) * CMP_W'(bs_plus1);
          rhs_r   <= CMP_W'(berr_r) * CMP_W'(s_plus1);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!have_r || lhs_r < rhs_r) begin
            have_r  <= 1'b1;
            bp_r    <= p_r;
            bs_r    <= s_r;
            bn_r    <= n_r;
            berr_r  <= err_r;
            bfreq_r <= prod_r;
          end
          if (err_r == '0) begin
            state_r <= S_DONE;
          end else if (s_r == POST_LAST) begin
            s_r <= '0;
            if (p_r == PRE_LAST) begin
              state_r <= S_DONE;
            end else begin
              p_r     <= p_r + 1'b1;
              state_r <= S_Q_GO;
            end
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_N_GO;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            o_pre_r     <= bp_r;
            o_n_r       <= bn_r;
            o_post_r    <= bs_r;
            o_err_r     <= berr_r;
            o_freq_r    <= bfreq_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pre_div       = o_pre_r;
  assign out_chan.feedback_int  = o_n_r[N_W-1:FRAC_W];
  assign out_chan.post_code     = o_post_r;
  assign out_chan.feedback_frac = o_n_r[FRAC_W-1:0];
  assign out_chan.error_num     = {{(ERR_W-TD_W){1'b0}}, o_err_r};
  assign out_chan.freq_num      = o_freq_r[FREQ_W-1:0];
  assign out_chan.denom         = {o_post_plus1, {FRAC_W{1'b0}}};
  assign out_chan.exact_hit     = (o_err_r == '0);

endmodule

[sv/pdsu_div.sv]
// pdsu_div: shared restoring divider, one quotient bit per cycle
// depends on pdsu_pkg; used by pll_divider_search_unit
module pdsu_div import pdsu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TD_W-1:0]   dividend,
  input  logic [REF_W-1:0]  divisor,
  output logic              done,
  output logic [TD_W-1:0]   quotient,
  output logic [REF_W-1:0]  remainder
);

  logic [TD_W-1:0]      quo_r;
  logic [REF_W-1:0]     rem_r;
  logic [REF_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [REF_W:0]   shifted;
  logic [REF_W:0]   diff;
  logic             fits;
  logic [REF_W-1:0] rem_step;

  always_comb begin
    shifted  = {rem_r, quo_r[TD_W-1]};
    fits     = shifted >= {1'b0, dvs_r};
    diff     = shifted - {1'b0, dvs_r};
    rem_step = fits ? diff[REF_W-1:0] : shifted[REF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[TD_W-2:0], fits};
        rem_r <= rem_step;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[sv/pdsu_cfg.sv]
// pdsu_cfg: apb register holding the reference clock frequency
// depends on pdsu_pkg; used by pll_divider_search_unit
module pdsu_cfg import pdsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [REF_W-1:0]      ref_clock_hz
);

  logic [REF_W-1:0] ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_REF_CLOCK) begin
      ref_r <= pwdata[REF_W-1:0];
    end
  end

  assign prdata       = (paddr == ADDR_REF_CLOCK) ? ref_r : '0;
  assign pready       = 1'b1;
  assign ref_clock_hz = ref_r;

endmodule
